FILE: src/tvp_pkg.sv
`timescale 1ns / 1ps

package tvp_pkg;

  localparam int POS_W      = 32;
  localparam int MAG_W      = 31;
  localparam int SQ_W       = 62;
  localparam int LIN_W      = 63;
  localparam int NUM_W      = 66;
  localparam int DEN_W      = 34;
  localparam int DW         = NUM_W + 1;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int ROOT_STEPS = 31;
  localparam int ROOT_CNT_W = 5;
  localparam int DIV_CNT_W  = 7;

  localparam logic [MAG_W-1:0] SAT_MAG = {MAG_W{1'b1}};

  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_DECEL  = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL  = 3'd0,
    CFG_DECEL  = 3'd1,
    CFG_CRUISE = 3'd2,
    CFG_ENTRY  = 3'd3,
    CFG_EXIT   = 3'd4,
    CFG_ORIGIN = 3'd5,
    CFG_GOAL   = 3'd6
  } cfg_reg_t;

  typedef enum logic [2:0] {
    PL_MUL,
    PL_LOAD,
    PL_DIV,
    PL_STORE,
    PL_FIN,
    PL_READY
  } plan_state_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_ROOT,
    BK_HOLD
  } bk_state_t;

  typedef struct packed {
    logic             ready;
    logic [MAG_W-1:0] a_eff;
    logic [MAG_W-1:0] b_eff;
    logic [MAG_W-1:0] cruise;
    logic [MAG_W-1:0] entry;
    logic [MAG_W-1:0] exit_spd;
    logic [POS_W-1:0] origin;
    logic [POS_W-1:0] move_len;
    logic             dir_neg;
    logic             dir_zero;
    logic [DW-1:0]    acc_d;
    logic [DW-1:0]    cend;
  } plan_t;

  typedef struct packed {
    phase_t           phase;
    logic             root;
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic [SQ_W-1:0]  sq;
    logic [LIN_W-1:0] lin;
  } q_entry_t;

endpackage

FILE: src/tvp_if.sv
`timescale 1ns / 1ps

interface tvp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] measured_position;

  modport source (output valid, output measured_position, input ready);
  modport sink (input valid, input measured_position, output ready);
endinterface

interface tvp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] speed_command;
  logic [1:0]  move_phase;

  modport source (output valid, output speed_command, output move_phase, input ready);
  modport sink (input valid, input speed_command, input move_phase, output ready);
endinterface

FILE: src/trapezoid_velocity_profile_1d.sv
`timescale 1ns / 1ps

// Trapezoidal velocity profile for one axis, Q16.16 fixed point.
// Seven registers (acceleration, deceleration, cruise, entry and exit speed,
// origin and goal position) are written through the cfg_ port, one register
// per cycle in which cfg_we is high. Each input beat on in_ch carries one
// measured position; each output beat on out_ch carries the signed target
// speed and the move phase for that position, in order, one per input.
// After reset and after every register write the block derives the phase
// distances with one shared multiplier and a bit-serial divider; in_ch.ready
// stays low until the derivation is done.
// An item then passes through the front stages, waits in a four-entry
// queue, and goes on to the back end, whose square root unit produces one
// result bit per cycle (31 steps). The back end works on one item at a time:
// it takes the next from the queue only once the last result has been
// loaded into the output register.
// When the receiver stalls, the result waits in the output register, the
// queue and front stages keep taking input until full, then in_ch.ready falls.
// Reset is synchronous and active low; it restores the register defaults.

module trapezoid_velocity_profile_1d (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tvp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tvp_pkg::POS_W-1:0]     cfg_data,
  tvp_in_if.sink                        in_ch,
  tvp_out_if.source                     out_ch
);

  tvp_pkg::plan_t    plan;
  tvp_pkg::q_entry_t push_data, pop_data;
  logic push_valid, push_ready, pop_valid, pop_ready;

  // Register file and distance derivation.
  tvp_plan u_plan (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .plan      (plan)
  );

  // Front end: distance travelled, phase decision, square-root operands.
  tvp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .plan       (plan),
    .in_ch      (in_ch),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // The queue decouples the front end from the slow back end.
  tvp_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back end: saturation, square root, sign and output register.
  tvp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

FILE: src/tvp_plan.sv
`timescale 1ns / 1ps

module tvp_plan (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tvp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tvp_pkg::POS_W-1:0]      cfg_data,
  output tvp_pkg::plan_t                 plan
);

  localparam int DW    = tvp_pkg::DW;
  localparam int NUM_W = tvp_pkg::NUM_W;
  localparam int DEN_W = tvp_pkg::DEN_W;

  logic [tvp_pkg::MAG_W-1:0] accel_r, decel_r, cruise_r, entry_r, exit_r;
  logic [tvp_pkg::POS_W-1:0] origin_r, goal_r;

  tvp_pkg::plan_state_t state_r, state_nxt;
  logic [1:0]                   sel_r, sel_nxt;
  logic [tvp_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;

  logic [tvp_pkg::SQ_W-1:0]  vc2_r, v02_r, ve2_r;
  logic [tvp_pkg::LIN_W-1:0] bd_r;
  logic [NUM_W-1:0]          nmag_r, quo_r;
  logic [DEN_W-1:0]          den_r, rem_r;
  logic                      neg_r;
  logic [DW-1:0]             dacc_r, ddec_r, tri_r, acc_d_r, cend_r;

  logic [tvp_pkg::MAG_W-1:0] a_eff, b_eff;
  logic signed [32:0]        span;
  logic [31:0]               move_len;
  logic [31:0]               mul_a, mul_b;
  logic [63:0]               product;
  logic signed [DW-1:0]      num_s;
  logic [DW-1:0]             num_abs;
  logic [DEN_W-1:0]          den_sel;
  logic [31:0]               ab_sum;
  logic [DEN_W:0]            trial, trial_diff;
  logic                      ge;
  logic [DW-1:0]             qext, qadj;
  logic signed [DW:0]        dsum;
  logic                      trap;
  logic [DW-1:0]             cend_trap;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r  <= tvp_pkg::MAG_W'(65536);
      decel_r  <= tvp_pkg::MAG_W'(65536);
      cruise_r <= '0;
      entry_r  <= '0;
      exit_r   <= '0;
      origin_r <= '0;
      goal_r   <= '0;
    end else if (cfg_we) begin
      case (tvp_pkg::cfg_reg_t'(cfg_index))
        tvp_pkg::CFG_ACCEL:  accel_r  <= cfg_data[tvp_pkg::MAG_W-1:0];
        tvp_pkg::CFG_DECEL:  decel_r  <= cfg_data[tvp_pkg::MAG_W-1:0];
        tvp_pkg::CFG_CRUISE: cruise_r <= cfg_data[tvp_pkg::MAG_W-1:0];
        tvp_pkg::CFG_ENTRY:  entry_r  <= cfg_data[tvp_pkg::MAG_W-1:0];
        tvp_pkg::CFG_EXIT:   exit_r   <= cfg_data[tvp_pkg::MAG_W-1:0];
        tvp_pkg::CFG_ORIGIN: origin_r <= cfg_data;
        tvp_pkg::CFG_GOAL:   goal_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign a_eff    = (accel_r == '0) ? tvp_pkg::MAG_W'(1) : accel_r;
  assign b_eff    = (decel_r == '0) ? tvp_pkg::MAG_W'(1) : decel_r;
  assign span     = $signed({goal_r[31], goal_r}) - $signed({origin_r[31], origin_r});
  assign move_len = span[32] ? 32'(-span) : span[31:0];

  // One shared multiplier, one product per cycle.
  always_comb begin
    case (sel_r)
      2'd0:    begin mul_a = {1'b0, cruise_r}; mul_b = {1'b0, cruise_r}; end
      2'd1:    begin mul_a = {1'b0, entry_r};  mul_b = {1'b0, entry_r};  end
      2'd2:    begin mul_a = {1'b0, exit_r};   mul_b = {1'b0, exit_r};   end
      default: begin mul_a = {1'b0, b_eff};    mul_b = move_len;         end
    endcase
  end
  assign product = mul_a * mul_b;

  // Dividend and divisor of the three distance divisions.
  assign ab_sum = {1'b0, a_eff} + {1'b0, b_eff};
  always_comb begin
    case (sel_r)
      2'd0: begin
        num_s   = $signed({{(DW-62){1'b0}}, vc2_r}) - $signed({{(DW-62){1'b0}}, v02_r});
        den_sel = {2'b0, a_eff, 1'b0};
      end
      2'd1: begin
        num_s   = $signed({{(DW-62){1'b0}}, vc2_r}) - $signed({{(DW-62){1'b0}}, ve2_r});
        den_sel = {2'b0, b_eff, 1'b0};
      end
      default: begin
        num_s   = $signed({{(DW-62){1'b0}}, ve2_r}) - $signed({{(DW-62){1'b0}}, v02_r})
                  + $signed({{(DW-64){1'b0}}, bd_r, 1'b0});
        den_sel = {1'b0, ab_sum, 1'b0};
      end
    endcase
  end
  assign num_abs = num_s[DW-1] ? DW'(-num_s) : DW'(num_s);

  // Restoring divider step, one quotient bit per cycle.
  assign trial      = {rem_r, nmag_r[NUM_W-1]};
  assign trial_diff = trial - {1'b0, den_r};
  assign ge         = (trial >= {1'b0, den_r});

  // Floor correction for a negative dividend.
  assign qext = {1'b0, quo_r} + DW'(rem_r != '0);
  assign qadj = neg_r ? DW'(-qext) : {1'b0, quo_r};

  assign dsum      = $signed({dacc_r[DW-1], dacc_r}) + $signed({ddec_r[DW-1], ddec_r});
  assign trap      = dsum <= $signed({{(DW+1-32){1'b0}}, move_len});
  assign cend_trap = DW'($signed({{(DW-32){1'b0}}, move_len}) - $signed(ddec_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tvp_pkg::PL_MUL;
      sel_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      tvp_pkg::PL_MUL: begin
        if (sel_r == 2'd3) begin
          state_nxt = tvp_pkg::PL_LOAD;
          sel_nxt   = '0;
        end else begin
          sel_nxt = sel_r + 2'd1;
        end
      end
      tvp_pkg::PL_LOAD: begin
        state_nxt = tvp_pkg::PL_DIV;
        cnt_nxt   = tvp_pkg::DIV_CNT_W'(NUM_W - 1);
      end
      tvp_pkg::PL_DIV: begin
        if (cnt_r == '0) begin
          state_nxt = tvp_pkg::PL_STORE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      tvp_pkg::PL_STORE: begin
        if (sel_r == 2'd2) begin
          state_nxt = tvp_pkg::PL_FIN;
        end else begin
          state_nxt = tvp_pkg::PL_LOAD;
          sel_nxt   = sel_r + 2'd1;
        end
      end
      tvp_pkg::PL_FIN:   state_nxt = tvp_pkg::PL_READY;
      tvp_pkg::PL_READY: state_nxt = tvp_pkg::PL_READY;
      default:           state_nxt = tvp_pkg::PL_MUL;
    endcase
    // Any register write starts the derivation over.
    if (cfg_we) begin
      state_nxt = tvp_pkg::PL_MUL;
      sel_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      tvp_pkg::PL_MUL: begin
        case (sel_r)
          2'd0:    vc2_r <= product[tvp_pkg::SQ_W-1:0];
          2'd1:    v02_r <= product[tvp_pkg::SQ_W-1:0];
          2'd2:    ve2_r <= product[tvp_pkg::SQ_W-1:0];
          default: bd_r  <= product[tvp_pkg::LIN_W-1:0];
        endcase
      end
      tvp_pkg::PL_LOAD: begin
        neg_r  <= num_s[DW-1];
        nmag_r <= num_abs[NUM_W-1:0];
        den_r  <= den_sel;
        quo_r  <= '0;
        rem_r  <= '0;
      end
      tvp_pkg::PL_DIV: begin
        rem_r  <= ge ? trial_diff[DEN_W-1:0] : trial[DEN_W-1:0];
        quo_r  <= {quo_r[NUM_W-2:0], ge};
        nmag_r <= {nmag_r[NUM_W-2:0], 1'b0};
      end
      tvp_pkg::PL_STORE: begin
        case (sel_r)
          2'd0:    dacc_r <= qadj;
          2'd1:    ddec_r <= qadj;
          default: tri_r  <= qadj;
        endcase
      end
      tvp_pkg::PL_FIN: begin
        acc_d_r <= trap ? dacc_r : tri_r;
        cend_r  <= trap ? cend_trap : tri_r;
      end
      default: ;
    endcase
  end

  assign plan.ready    = (state_r == tvp_pkg::PL_READY);
  assign plan.a_eff    = a_eff;
  assign plan.b_eff    = b_eff;
  assign plan.cruise   = cruise_r;
  assign plan.entry    = entry_r;
  assign plan.exit_spd = exit_r;
  assign plan.origin   = origin_r;
  assign plan.move_len = move_len;
  assign plan.dir_neg  = span[32];
  assign plan.dir_zero = (span == '0);
  assign plan.acc_d    = acc_d_r;
  assign plan.cend     = cend_r;

endmodule

FILE: src/tvp_front.sv
`timescale 1ns / 1ps

module tvp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  tvp_pkg::plan_t    plan,
  tvp_in_if.sink            in_ch,
  output logic              push_valid,
  input  logic              push_ready,
  output tvp_pkg::q_entry_t push_data
);

  localparam int DW = tvp_pkg::DW;

  logic advance, accept;
  logic s1_valid_r, s2_valid_r;

  tvp_pkg::phase_t           s1_phase_r, s2_phase_r;
  logic                      s1_root_r, s2_root_r, s1_neg_r, s2_neg_r;
  logic [tvp_pkg::MAG_W-1:0] s1_base_r, s2_mag_r, s1_lim_r;
  logic [31:0]               s1_rd_r;
  logic [tvp_pkg::SQ_W-1:0]  s2_sq_r;
  logic [tvp_pkg::LIN_W-1:0] s2_lin_r;

  logic signed [32:0]        diff;
  logic [31:0]               trav;
  logic signed [DW-1:0]      trav_s;
  tvp_pkg::phase_t           c_phase;
  logic                      c_root;
  logic [tvp_pkg::MAG_W-1:0] c_base, c_lim;
  logic [31:0]               c_rd;
  logic [tvp_pkg::SQ_W-1:0]  sq_full;
  logic [tvp_pkg::LIN_W-1:0] lin_full;

  assign advance     = !s2_valid_r || push_ready;
  assign in_ch.ready = plan.ready && advance;
  assign accept      = in_ch.valid && in_ch.ready;

  always_comb begin
    diff   = $signed({in_ch.measured_position[31], in_ch.measured_position})
             - $signed({plan.origin[31], plan.origin});
    trav   = diff[32] ? 32'(-diff) : diff[31:0];
    trav_s = $signed({{(DW-32){1'b0}}, trav});
    c_phase = tvp_pkg::PH_DONE;
    c_root  = 1'b0;
    c_base  = plan.dir_zero ? '0 : plan.exit_spd;
    c_lim   = plan.b_eff;
    c_rd    = '0;
    if (trav >= plan.move_len) begin
      c_phase = tvp_pkg::PH_DONE;
    end else if (trav_s < $signed(plan.acc_d)) begin
      c_phase = tvp_pkg::PH_ACCEL;
      c_root  = 1'b1;
      c_base  = plan.entry;
      c_lim   = plan.a_eff;
      c_rd    = trav;
    end else if (trav_s < $signed(plan.cend)) begin
      c_phase = tvp_pkg::PH_CRUISE;
      c_base  = plan.cruise;
    end else begin
      c_phase = tvp_pkg::PH_DECEL;
      c_root  = 1'b1;
      c_base  = plan.exit_spd;
      c_lim   = plan.b_eff;
      c_rd    = plan.move_len - trav;
    end
  end

  assign sq_full  = s1_base_r * s1_base_r;
  assign lin_full = s1_lim_r * s1_rd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_phase_r <= c_phase;
      s1_root_r  <= c_root;
      s1_neg_r   <= plan.dir_neg;
      s1_base_r  <= c_base;
      s1_lim_r   <= c_lim;
      s1_rd_r    <= c_rd;
      s2_phase_r <= s1_phase_r;
      s2_root_r  <= s1_root_r;
      s2_neg_r   <= s1_neg_r;
      s2_mag_r   <= s1_base_r;
      s2_sq_r    <= sq_full;
      s2_lin_r   <= lin_full;
    end
  end

  assign push_valid      = s2_valid_r;
  assign push_data.phase = s2_phase_r;
  assign push_data.root  = s2_root_r;
  assign push_data.neg   = s2_neg_r;
  assign push_data.mag   = s2_mag_r;
  assign push_data.sq    = s2_sq_r;
  assign push_data.lin   = s2_lin_r;

endmodule

FILE: src/tvp_fifo.sv
`timescale 1ns / 1ps

module tvp_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  tvp_pkg::q_entry_t push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output tvp_pkg::q_entry_t pop_data
);

  tvp_pkg::q_entry_t mem_r [tvp_pkg::FIFO_DEPTH];
  logic [tvp_pkg::FIFO_AW-1:0] wptr_r, rptr_r;
  logic [tvp_pkg::FIFO_AW:0]   count_r;
  logic do_push, do_pop;

  assign push_ready = (count_r != (tvp_pkg::FIFO_AW+1)'(tvp_pkg::FIFO_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem_r[rptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (do_push) wptr_r <= wptr_r + 1'b1;
      if (do_pop)  rptr_r <= rptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wptr_r] <= push_data;
  end

endmodule

FILE: src/tvp_back.sv
`timescale 1ns / 1ps

module tvp_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              pop_valid,
  output logic              pop_ready,
  input  tvp_pkg::q_entry_t pop_data,
  tvp_out_if.source         out_ch
);

  localparam int SQ_W = tvp_pkg::SQ_W;

  tvp_pkg::bk_state_t state_r, state_nxt;
  logic [tvp_pkg::ROOT_CNT_W-1:0] cnt_r;
  logic [SQ_W-1:0] x_r, r_r, bit_r;
  tvp_pkg::phase_t phase_r, out_phase_r;
  logic            neg_r;
  logic            out_valid_r;
  logic [31:0]     out_speed_r;

  logic [SQ_W+2:0] rad;
  logic            sat;
  logic [SQ_W-1:0] sum;
  logic            ge;
  logic [31:0]     mag32;
  logic            load_out;

  assign rad = {3'b0, pop_data.sq} + {1'b0, pop_data.lin, 1'b0};
  assign sat = |rad[SQ_W+2:SQ_W];

  // Digit-by-digit square root, one result bit per cycle.
  assign sum = r_r + bit_r;
  assign ge  = (x_r >= sum);

  assign mag32     = {1'b0, r_r[tvp_pkg::MAG_W-1:0]};
  assign load_out  = (state_r == tvp_pkg::BK_HOLD) && (!out_valid_r || out_ch.ready);
  assign pop_ready = (state_r == tvp_pkg::BK_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tvp_pkg::BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tvp_pkg::BK_IDLE: begin
        if (pop_valid) begin
          state_nxt = (pop_data.root && !sat) ? tvp_pkg::BK_ROOT : tvp_pkg::BK_HOLD;
        end
      end
      tvp_pkg::BK_ROOT: begin
        if (cnt_r == '0) state_nxt = tvp_pkg::BK_HOLD;
      end
      tvp_pkg::BK_HOLD: begin
        if (load_out) state_nxt = tvp_pkg::BK_IDLE;
      end
      default: state_nxt = tvp_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      tvp_pkg::BK_IDLE: begin
        phase_r <= pop_data.phase;
        neg_r   <= pop_data.neg;
        x_r     <= rad[SQ_W-1:0];
        bit_r   <= SQ_W'(1) << (2 * (tvp_pkg::ROOT_STEPS - 1));
        cnt_r   <= tvp_pkg::ROOT_CNT_W'(tvp_pkg::ROOT_STEPS - 1);
        if (pop_data.root && !sat) begin
          r_r <= '0;
        end else if (pop_data.root) begin
          r_r <= {{(SQ_W-tvp_pkg::MAG_W){1'b0}}, tvp_pkg::SAT_MAG};
        end else begin
          r_r <= {{(SQ_W-tvp_pkg::MAG_W){1'b0}}, pop_data.mag};
        end
      end
      tvp_pkg::BK_ROOT: begin
        x_r   <= ge ? (x_r - sum) : x_r;
        r_r   <= ge ? ((r_r >> 1) + bit_r) : (r_r >> 1);
        bit_r <= bit_r >> 2;
        cnt_r <= cnt_r - 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_speed_r <= neg_r ? (32'd0 - mag32) : mag32;
      out_phase_r <= phase_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.speed_command = out_speed_r;
  assign out_ch.move_phase    = out_phase_r;

endmodule

FILE: src/tvp_checker.sv
`timescale 1ns / 1ps

module tvp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_we,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_speed,
  input logic [1:0]  out_phase
);

  logic [3:0] pend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      case ({in_valid && in_ready, out_valid && out_ready})
        2'b10:   pend_r <= pend_r + 1'b1;
        2'b01:   pend_r <= pend_r - 1'b1;
        default: pend_r <= pend_r;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_speed) && $stable(out_phase))
    else $error("result changed while stalled");

  a_cfg_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> !in_ready)
    else $error("input taken before distances were derived again");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 4'd0)
    else $error("result without an outstanding item");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 4'd8)
    else $error("more items in flight than the pipeline holds");

endmodule

bind trapezoid_velocity_profile_1d tvp_checker u_tvp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .cfg_we    (cfg_we),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_speed (out_ch.speed_command),
  .out_phase (out_ch.move_phase)
);

FILE: tb/tvp_profile_checker.sv
`timescale 1ns / 1ps

module tvp_profile_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [tvp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [tvp_pkg::POS_W-1:0]     cfg_data,
  tvp_in_if                             in_mon,
  tvp_out_if                            out_mon,
  output int                            fail_count,
  output int                            pending_count,
  output int                            done_count
);

  typedef struct packed {
    logic [31:0]     speed;
    tvp_pkg::phase_t phase;
  } speed_beat_t;

  // Shadow copy of the move registers.
  logic [30:0] accel_r, decel_r, cruise_r, entry_r, exit_r;
  logic [31:0] origin_r, goal_r;

  speed_beat_t expected_q[$];

  assign pending_count = expected_q.size();

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    if (fail_count < 20)
      $display("mismatch %s at %0t: got %h, expected %h", what, $realtime, got, want);
    fail_count++;
  endtask

  function automatic longint floor_div(input longint n, input longint d);
    longint q;
    q = n / d;
    if (n % d < 0) q--;
    return q;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Speed after ramping over a distance from a base speed, saturated.
  function automatic longint ramp_speed(input longint unsigned base, input longint unsigned lim,
                                        input longint unsigned run_len);
    logic [64:0] rad;
    rad = {1'b0, base * base} + {1'b0, 64'd2 * lim * run_len};
    if (rad >= (65'd1 << 62)) return longint'(tvp_pkg::SAT_MAG);
    return longint'(root_floor(rad[63:0]));
  endfunction

  function automatic speed_beat_t profile_speed(input logic [31:0] meas);
    longint a, b, vc2, v02, ve2, org, span, dir, move_len, trav, acc_d, dec_d, mag;
    longint dacc, ddec, den, q1, r1, pv, qp, rp;
    longint unsigned qv;
    speed_beat_t res;
    a    = (accel_r == 0) ? 1 : longint'(accel_r);
    b    = (decel_r == 0) ? 1 : longint'(decel_r);
    vc2  = longint'(cruise_r) * longint'(cruise_r);
    v02  = longint'(entry_r) * longint'(entry_r);
    ve2  = longint'(exit_r) * longint'(exit_r);
    org  = longint'($signed(origin_r));
    span = longint'($signed(goal_r)) - org;
    dir  = (span > 0) ? 1 : ((span < 0) ? -1 : 0);
    move_len = (span < 0) ? -span : span;
    trav = longint'($signed(meas)) - org;
    if (trav < 0) trav = -trav;
    if (trav >= move_len) begin
      res.phase = tvp_pkg::PH_DONE;
      mag = longint'(exit_r);
    end else begin
      dacc = floor_div(vc2 - v02, 2 * a);
      ddec = floor_div(vc2 - ve2, 2 * b);
      if (dacc + ddec <= move_len) begin
        acc_d = dacc;
        dec_d = ddec;
      end else begin
        // Triangle: the peak speed is reached where both ramps meet.
        den   = 2 * (a + b);
        qv    = 64'd2 * longint'(b) * longint'(move_len);
        q1    = longint'(qv / den);
        r1    = longint'(qv % den);
        pv    = ve2 - v02;
        qp    = floor_div(pv, den);
        rp    = pv - qp * den;
        acc_d = q1 + qp + (((r1 + rp) >= den) ? 1 : 0);
        dec_d = move_len - acc_d;
      end
      if (trav < acc_d) begin
        res.phase = tvp_pkg::PH_ACCEL;
        mag = ramp_speed(entry_r, a, trav);
      end else if (trav < move_len - dec_d) begin
        res.phase = tvp_pkg::PH_CRUISE;
        mag = longint'(cruise_r);
      end else begin
        res.phase = tvp_pkg::PH_DECEL;
        mag = ramp_speed(exit_r, b, move_len - trav);
      end
    end
    res.speed = 32'(mag * dir);
    return res;
  endfunction

  always @(posedge clk) begin
    speed_beat_t want;
    if (!rst_n) begin
      accel_r    <= 31'd65536;
      decel_r    <= 31'd65536;
      cruise_r   <= '0;
      entry_r    <= '0;
      exit_r     <= '0;
      origin_r   <= '0;
      goal_r     <= '0;
      fail_count <= 0;
      done_count <= 0;
      expected_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tvp_pkg::CFG_ACCEL:  accel_r  <= cfg_data[30:0];
          tvp_pkg::CFG_DECEL:  decel_r  <= cfg_data[30:0];
          tvp_pkg::CFG_CRUISE: cruise_r <= cfg_data[30:0];
          tvp_pkg::CFG_ENTRY:  entry_r  <= cfg_data[30:0];
          tvp_pkg::CFG_EXIT:   exit_r   <= cfg_data[30:0];
          tvp_pkg::CFG_ORIGIN: origin_r <= cfg_data;
          tvp_pkg::CFG_GOAL:   goal_r   <= cfg_data;
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        expected_q.push_back(profile_speed(in_mon.measured_position));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_q.size() == 0) begin
          report("unexpected beat", out_mon.speed_command, 32'd0);
        end else begin
          want = expected_q.pop_front();
          if (out_mon.speed_command !== want.speed)
            report("speed_command", out_mon.speed_command, want.speed);
          if (out_mon.move_phase !== want.phase)
            report("move_phase", 32'(out_mon.move_phase), 32'(want.phase));
          if (out_mon.move_phase == tvp_pkg::PH_DONE) done_count <= done_count + 1;
        end
      end
    end
  end
endmodule

FILE: tb/trapezoid_velocity_profile_1d_test.sv
`timescale 1ns / 1ps

module trapezoid_velocity_profile_1d_test;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [tvp_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tvp_pkg::POS_W-1:0]     cfg_data;

  // When quiet is set, neither side inserts idle cycles.
  logic quiet;
  int   fail_count, pending_count, done_count;
  int   beats_sent, settings_used;

  tvp_in_if  in_ch ();
  tvp_out_if out_ch ();

  trapezoid_velocity_profile_1d u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source)
  );

  tvp_profile_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_mon        (in_ch),
    .out_mon       (out_ch),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .done_count    (done_count)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // The receiver stalls at random about 31 percent of the time unless quiet is set.
  always @(posedge clk) begin
    out_ch.ready <= quiet ? 1'b1 : ($urandom_range(99) >= 31);
  end

  // Hard limit on the run, far above the slowest correct run.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Sends one position beat. Valid stays high from one beat to the next, so it
  // is only lowered when the sender decides to idle.
  task automatic send_position(input logic [31:0] pos);
    while (!quiet && $urandom_range(99) < 31) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.measured_position <= pos;
    do @(posedge clk); while (!in_ch.ready);
    beats_sent++;
  endtask

  // Lets every expected beat arrive, then a margin that covers the back end.
  task automatic drain;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  // Writes all seven registers on back-to-back cycles while the block is idle.
  task automatic load_move(input logic [30:0] accel, input logic [30:0] decel,
                           input logic [30:0] cruise, input logic [30:0] entry,
                           input logic [30:0] exit_spd, input logic [31:0] origin,
                           input logic [31:0] goal);
    logic [31:0]       vals[7];
    tvp_pkg::cfg_reg_t idx;
    vals = '{{1'b0, accel}, {1'b0, decel}, {1'b0, cruise}, {1'b0, entry},
             {1'b0, exit_spd}, origin, goal};
    drain();
    idx = tvp_pkg::CFG_ACCEL;
    for (int i = 0; i < 7; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= vals[i];
      @(posedge clk);
      idx = idx.next();
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Random magnitude: zero, full scale, or a random value at a random scale.
  function automatic logic [30:0] rand_mag;
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return 31'($urandom >> $urandom_range(31));
    endcase
  endfunction

  function automatic logic [31:0] rand_pos;
    case ($urandom_range(9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      default: return 32'($signed($urandom) >>> $urandom_range(31));
    endcase
  endfunction

  // A position along the move, slightly beyond both ends too, or anywhere.
  function automatic logic [31:0] pos_on_move(input logic [31:0] origin, input logic [31:0] goal);
    longint span;
    if ($urandom_range(99) < 20) return $urandom;
    span = longint'($signed(goal)) - longint'($signed(origin));
    return 32'(longint'($signed(origin)) + span * longint'(int'($urandom_range(72)) - 4) / 64);
  endfunction

  initial begin
    logic [31:0] org, goal;
    rst_n       = 1'b0;
    quiet       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = tvp_pkg::CFG_ACCEL;
    cfg_data    = '0;
    in_ch.valid = 1'b0;
    in_ch.measured_position = '0;
    out_ch.ready = 1'b0;
    beats_sent    = 0;
    settings_used = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Register defaults describe a zero-length move: always finished, speed 0.
    send_position(32'h0000_0000);
    send_position(32'h8000_0000);
    send_position(32'h7FFF_FFFF);

    // Plain trapezoid forward: 1.0 accel and decel, cruise 10.0, 1000.0 long.
    load_move(31'h1_0000, 31'h1_0000, 31'hA_0000, '0, '0, 32'h0, 32'h03E8_0000);
    send_position(32'h0);
    send_position(32'h0010_0000);
    send_position(32'h01F4_0000);
    send_position(32'h03E0_0000);
    send_position(32'h03E8_0000);
    send_position(32'hFFF0_0000);

    // Triangle backward with unequal limits and nonzero end speeds.
    load_move(31'h2_0000, 31'h0_8000, 31'h7FFF_FFFF, 31'h1_0000, 31'h3_0000,
              32'h0010_0000, 32'hFFF0_0000);
    send_position(32'h0008_0000);
    send_position(32'h0);
    send_position(32'hFFF8_0000);
    send_position(32'h8000_0000);

    // Zero limits count as one; entry above cruise skips acceleration.
    load_move('0, '0, 31'h10, 31'h100, '0, 32'h0, 32'h0000_1000);
    send_position(32'h0);
    send_position(32'h0800);
    send_position(32'h0FFF);

    // Full-scale registers over the widest span: the speed saturates.
    load_move('1, '1, '1, '1, '1, 32'h8000_0000, 32'h7FFF_FFFF);
    send_position(32'h8000_0000);
    send_position(32'h0);
    send_position(32'h7FFF_FFFE);
    send_position(32'h7FFF_FFFF);

    // Random moves, most beats placed along the move. One setting runs with
    // no idling at all, and the sender once waits for the block to drain.
    for (int s = 0; s < 10; s++) begin
      org  = rand_pos();
      goal = ($urandom_range(9) == 0) ? org : rand_pos();
      load_move(rand_mag(), rand_mag(), rand_mag(), rand_mag(), rand_mag(), org, goal);
      quiet = (s == 4);
      for (int i = 0; i < 45; i++) begin
        if (s == 6 && i == 20) begin
          in_ch.valid <= 1'b0;
          @(posedge clk);
          while (pending_count != 0) @(posedge clk);
        end
        send_position(pos_on_move(org, goal));
      end
      quiet = 1'b0;
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Sent %0d position beats over %0d move settings plus reset defaults.",
             beats_sent, settings_used);
    $display("%0d beats came back in the finished phase.", done_count);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
